FILE: hdl/frm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate meter package
// Shared widths, event codes, register map and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package frm_pkg;

	// Field widths.
	localparam int TS_W   = 48;
	localparam int RATE_W = 32;
	localparam int TUPS_W = 30;
	localparam int KIND_W = 2;
	localparam int FRAC_W = 8;

	// Event kinds carried on the input tuser.
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STOP   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESUME = 2'd2;

	// Register map.
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-3:0] REG_TUPS = 1'd0;
	localparam logic [TUPS_W-1:0] TUPS_RESET = 30'd1000000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic sub;
		logic add;
		logic mul;
		logic div;
		logic load_out;
	} frm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic tick_go;
		logic div_last;
	} frm_stat_t;

endpackage

FILE: hdl/frm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate meter datapath
// Holds the timing state, the ring of recent frame deltas, the running sum
// and a restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frm_dp
	import frm_pkg::*;
#(
	parameter int WINDOW = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  frm_cmd_t          cmd,
	output frm_stat_t         stat,
	input  logic [KIND_W-1:0] kind,
	input  logic [TS_W-1:0]   timestamp,
	input  logic [TUPS_W-1:0] tups,
	output logic [TS_W-1:0]   frame_delta,
	output logic [RATE_W-1:0] frame_rate
);

	localparam int AW  = $clog2(WINDOW);
	localparam int CW  = $clog2(WINDOW + 1);
	localparam int SW  = TS_W + AW;
	localparam int PW  = CW + TUPS_W;
	localparam int NW  = PW + FRAC_W;
	localparam int DCW = $clog2(NW + 1);

	logic              stopped_q;
	logic [TS_W-1:0]   ref_q;
	logic [TS_W-1:0]   held_q;
	logic [TS_W-1:0]   since_s1;
	logic [TS_W-1:0]   delta_q;
	logic [TS_W-1:0]   ring [WINDOW];
	logic [TS_W-1:0]   rd_q;
	logic [SW-1:0]     sum_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     wpos_q;
	logic [NW-1:0]     numer_q;
	logic [SW-1:0]     rem_q;
	logic [NW-1:0]     quot_q;
	logic [DCW-1:0]    dcnt_q;
	logic [TS_W-1:0]   out_delta_q;
	logic [RATE_W-1:0] out_rate_q;

	logic [TS_W-1:0]   elapsed;
	logic [TS_W:0]     delta_sum;
	logic              full;
	logic [PW-1:0]     prod;
	logic [SW:0]       trial;
	logic [SW:0]       trial_diff;
	logic              qbit;

	// Time since the reference, modulo the timestamp range.
	assign elapsed = timestamp - ref_q;
	assign full    = (cnt_q == CW'(WINDOW));

	// Frame delta before saturation.
	assign delta_sum = {1'b0, held_q} + {1'b0, since_s1};

	// Numerator product; the Q8 shift is applied when it is registered.
	assign prod = PW'(cnt_q) * PW'(tups);

	// One restoring division step.
	assign trial      = {rem_q, numer_q[NW-1]};
	assign trial_diff = trial - {1'b0, sum_q};
	assign qbit       = (trial >= {1'b0, sum_q});

	assign stat.tick_go  = (kind == KIND_TICK) && !stopped_q;
	assign stat.div_last = (dcnt_q == DCW'(1));

	assign frame_delta = out_delta_q;
	assign frame_rate  = out_rate_q;

	// Event handling and window bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q <= 1'b0;
			ref_q     <= '0;
			held_q    <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
			wpos_q    <= '0;
		end else begin
			if (cmd.take) begin
				case (kind)
					KIND_STOP: begin
						stopped_q <= 1'b1;
						held_q    <= elapsed;
					end
					KIND_RESUME: begin
						if (stopped_q) begin
							ref_q <= timestamp;
						end
						stopped_q <= 1'b0;
					end
					KIND_TICK: begin
						if (!stopped_q) begin
							ref_q <= timestamp;
						end
					end
					default: begin
					end
				endcase
			end
			// Clear the held time and retire the oldest delta once the window is full.
			if (cmd.sub) begin
				held_q <= '0;
				if (full) begin
					sum_q <= sum_q - SW'(rd_q);
				end
			end
			if (cmd.add) begin
				sum_q  <= sum_q + SW'(delta_q);
				wpos_q <= (wpos_q == AW'(WINDOW - 1)) ? '0 : wpos_q + 1'b1;
				if (!full) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Payload registers and the delta ring.
	always_ff @(posedge clk) begin
		rd_q <= ring[wpos_q];
		if (cmd.take) begin
			since_s1 <= elapsed;
		end
		if (cmd.sub) begin
			delta_q <= delta_sum[TS_W] ? '1 : delta_sum[TS_W-1:0];
		end
		if (cmd.add) begin
			ring[wpos_q] <= delta_q;
		end
	end

	// Divider. A zero sum makes every step succeed, so the quotient is all
	// ones and the rate saturates to its maximum.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			numer_q <= {prod, FRAC_W'(0)};
			rem_q   <= '0;
			quot_q  <= '0;
			dcnt_q  <= DCW'(NW);
		end else if (cmd.div) begin
			numer_q <= {numer_q[NW-2:0], 1'b0};
			quot_q  <= {quot_q[NW-2:0], qbit};
			rem_q   <= qbit ? trial_diff[SW-1:0] : trial[SW-1:0];
			dcnt_q  <= dcnt_q - 1'b1;
		end
		if (cmd.load_out) begin
			out_delta_q <= delta_q;
			out_rate_q  <= (|quot_q[NW-1:RATE_W]) ? '1 : quot_q[RATE_W-1:0];
		end
	end

`ifndef NO_ASSERTIONS
	// The fill count never passes the window length.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(WINDOW))
		else $error("fill count exceeds window");

	// Until the ring is full the write position follows the fill count.
	a_wpos_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != CW'(WINDOW)) |-> (wpos_q == cnt_q[AW-1:0]))
		else $error("write position out of step with fill count");

	// A stop event always leaves the meter stopped.
	a_stop_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && (kind == KIND_STOP)) |=> stopped_q)
		else $error("stop event did not stop the meter");
`endif

endmodule

FILE: hdl/frm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate meter controller
// Sequences one tick through window update, product, division and output,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module frm_ctrl
	import frm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  frm_stat_t stat,
	output frm_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SUB  = 6'b000010,
		S_ADD  = 6'b000100,
		S_MUL  = 6'b001000,
		S_DIV  = 6'b010000,
		S_DONE = 6'b100000
	} frm_state_t;

	frm_state_t state_q;
	frm_state_t state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Command decode.
	always_comb begin
		cmd          = '0;
		cmd.take     = in_valid && in_ready;
		cmd.sub      = (state_q == S_SUB);
		cmd.add      = (state_q == S_ADD);
		cmd.mul      = (state_q == S_MUL);
		cmd.div      = (state_q == S_DIV);
		cmd.load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.take && stat.tick_go) begin
					state_d = S_SUB;
				end
			end
			S_SUB: begin
				state_d = S_ADD;
			end
			S_ADD: begin
				state_d = S_MUL;
			end
			S_MUL: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (stat.div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (cmd.load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// A running tick starts the window update on the next cycle.
	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && stat.tick_go) |=> (state_q == S_SUB))
		else $error("tick did not start processing");

	// The last division step hands over to the output stage.
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIV) && stat.div_last) |=> (state_q == S_DONE))
		else $error("division did not finish");

	// Loading a result always presents it on the next cycle.
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");
`endif

endmodule

FILE: hdl/frame_rate_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate meter
// Moving-average frame rate over timestamped tick, stop and resume events.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a 48-bit timestamp on s_axis_tdata and the event kind
//   on s_axis_tuser (tick, stop or resume). Stop, resume, unknown kinds and
//   ticks while stopped leave the meter idle and give no output beat.
//   A running tick gives one output beat with the frame delta and the
//   average rate in Q24.8 frames per second. After acceptance it passes
//   through the sub, add, mul, div and done states; in div the bit-serial
//   divider walks the numerator of NW = clog2(WINDOW+1) + 38 bits (45 at
//   the default window of 64). The input is held off until the result is loaded.
//   A finished result sits in the output register; the next beat is taken
//   while it waits. If the receiver stalls, a following tick waits in its
//   last stage until the output register is free.
//   time_units_per_second is written over the APB port at address 0. The user
//   must write it only while the meter is idle; the block does not enforce it.
//   Reset clears the stopped flag, reference and held times, the running sum,
//   the fill count and the write position; the ring needs no clearing.
// ----------------------------------------------------------------------------
module frame_rate_meter
	import frm_pkg::*;
#(
	parameter int WINDOW = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	// APB configuration port.
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	// Event stream.
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [TS_W-1:0]     s_axis_tdata,   // [47:0] timestamp
	input  logic [KIND_W-1:0]   s_axis_tuser,   // [1:0] kind
	// Result stream.
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [TS_W+RATE_W-1:0] m_axis_tdata // [47:0] frame_delta, [79:48] frame_rate
);

	logic [TUPS_W-1:0] tups_q;
	logic              reg_hit;
	frm_cmd_t          cmd;
	frm_stat_t         stat;
	logic [TS_W-1:0]   frame_delta;
	logic [RATE_W-1:0] frame_rate;

	// Register decode on the word address.
	assign reg_hit = (paddr[APB_AW-1:2] == REG_TUPS);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? APB_DW'(tups_q) : '0;

	// Timestamp units per second register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tups_q <= TUPS_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			tups_q <= pwdata[TUPS_W-1:0];
		end
	end

	frm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	frm_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.kind        (s_axis_tuser),
		.timestamp   (s_axis_tdata),
		.tups        (tups_q),
		.frame_delta (frame_delta),
		.frame_rate  (frame_rate)
	);

	assign m_axis_tdata = {frame_rate, frame_delta};

endmodule
